// ===== rtl/core/trb_rpp_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// trb_rpp_pkg: shared types and constants of the ring producer pointer
// Holds the item, result and pointer-state types, the register indexes and
// the limits on the region and slot counts.
// -----------------------------------------------------------------------------
package trb_rpp_pkg;

   localparam int unsigned REGION_W = 4;
   localparam int unsigned SLOT_W   = 8;
   localparam int unsigned RCOUNT_W = 5;
   localparam int unsigned CSR_DATA_W = 8;

   // Largest number of regions and of usable slots per region.
   localparam logic [RCOUNT_W-1:0] MAX_REGIONS = 5'd16;
   localparam logic [SLOT_W-1:0]   MAX_SLOTS   = 8'd255;

   localparam logic [RCOUNT_W-1:0] REGION_COUNT_RESET     = 5'd1;
   localparam logic [SLOT_W-1:0]   SLOTS_PER_REGION_RESET = 8'd255;

   // Register indexes on the configuration port.
   localparam logic CSR_REGION_COUNT     = 1'b0;
   localparam logic CSR_SLOTS_PER_REGION = 1'b1;

   // Item kinds.
   localparam logic KIND_ADVANCE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [REGION_W-1:0] deq_region;
      logic [SLOT_W-1:0]   deq_slot;
   } item_type;

   typedef struct packed {
      logic                stamped;
      logic [REGION_W-1:0] stamp_region;
      logic [SLOT_W-1:0]   stamp_slot;
      logic                stamp_cycle;
      logic                link_stamped;
      logic [REGION_W-1:0] enq_region;
      logic [SLOT_W-1:0]   enq_slot;
      logic                cycle_state;
      logic                ring_full;
   } result_type;

   typedef struct packed {
      logic [REGION_W-1:0] enq_region;
      logic [SLOT_W-1:0]   enq_slot;
      logic                cycle;
      logic [REGION_W-1:0] deq_region;
      logic [SLOT_W-1:0]   deq_slot;
   } ptr_state_type;

endpackage

// ===== rtl/core/trb_rpp_req_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// trb_rpp_req_if: request channel of the ring producer pointer
// Valid/ready channel carrying one advance or dequeue-update item per beat.
// -----------------------------------------------------------------------------
interface trb_rpp_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [3:0] deq_region;
   logic [7:0] deq_slot;

   modport source (output valid, output kind, output deq_region, output deq_slot,
                   input ready);
   modport sink   (input valid, input kind, input deq_region, input deq_slot,
                   output ready);
endinterface

// ===== rtl/core/trb_rpp_rsp_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// trb_rpp_rsp_if: response channel of the ring producer pointer
// Valid/ready channel carrying one result per beat.
// -----------------------------------------------------------------------------
interface trb_rpp_rsp_if;
   logic       valid;
   logic       ready;
   logic       stamped;
   logic [3:0] stamp_region;
   logic [7:0] stamp_slot;
   logic       stamp_cycle;
   logic       link_stamped;
   logic [3:0] enq_region;
   logic [7:0] enq_slot;
   logic       cycle_state;
   logic       ring_full;

   modport source (output valid, output stamped, output stamp_region,
                   output stamp_slot, output stamp_cycle, output link_stamped,
                   output enq_region, output enq_slot, output cycle_state,
                   output ring_full, input ready);
   modport sink   (input valid, input stamped, input stamp_region,
                   input stamp_slot, input stamp_cycle, input link_stamped,
                   input enq_region, input enq_slot, input cycle_state,
                   input ring_full, output ready);
endinterface

// ===== rtl/core/trb_ring_producer_pointer.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// trb_ring_producer_pointer: producer-side pointer of a multi-region ring
// Usage: each beat on req_bus is either an advance (kind 0), which stamps the
// current enqueue slot with the producer cycle bit and moves on by one slot,
// or a dequeue update (kind 1), which records the consumer position. Every
// request beat yields exactly one beat on rsp_bus with the stamp details,
// the new enqueue position, the cycle state and the ring-full flag.
// The beat is held in the request register, and the pointer update then
// loads the response register. Throughput is one item per clock while
// rsp_bus is not stalled; the pointer update is a single increment, compare
// and cycle-bit decision. When rsp_bus is stalled the response register
// holds and the request register still takes one further beat before
// req_bus.ready drops. Reset (synchronous, active high) empties both
// registers, sets the enqueue and dequeue positions to region 0, slot 0,
// the cycle state to 1, and the registers to one region of 255 slots.
// The csr_ port writes region_count (index 0) and slots_per_region
// (index 1); the user must write them only while idle, and the block
// itself does not enforce this.
// -----------------------------------------------------------------------------
module trb_ring_producer_pointer (
   input  logic                                  clock,
   input  logic                                  reset,
   trb_rpp_req_if.sink                           req_bus,
   trb_rpp_rsp_if.source                         rsp_bus,
   input  logic                                  csr_write_enable,
   input  logic                                  csr_index,
   input  logic [trb_rpp_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic [trb_rpp_pkg::RCOUNT_W-1:0] region_count_ff;
   logic [trb_rpp_pkg::SLOT_W-1:0]   slots_per_region_ff;

   logic                        req_valid_ff;
   trb_rpp_pkg::item_type       item_ff;
   logic                        rsp_valid_ff;
   trb_rpp_pkg::result_type     result_ff;
   trb_rpp_pkg::ptr_state_type  state_ff;

   trb_rpp_pkg::ptr_state_type  state_in;
   trb_rpp_pkg::result_type     result_in;
   logic                        rsp_free;
   logic                        step_fire;
   logic                        req_fire;

   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;
   assign step_fire = req_valid_ff && rsp_free;
   assign req_bus.ready = !req_valid_ff || rsp_free;
   assign req_fire  = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_count_ff     <= trb_rpp_pkg::REGION_COUNT_RESET;
         slots_per_region_ff <= trb_rpp_pkg::SLOTS_PER_REGION_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            trb_rpp_pkg::CSR_REGION_COUNT: begin
               region_count_ff <= csr_write_data[trb_rpp_pkg::RCOUNT_W-1:0];
            end
            trb_rpp_pkg::CSR_SLOTS_PER_REGION: begin
               slots_per_region_ff <= csr_write_data[trb_rpp_pkg::SLOT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         req_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.kind       <= req_bus.kind;
         item_ff.deq_region <= req_bus.deq_region;
         item_ff.deq_slot   <= req_bus.deq_slot;
      end
   end

   trb_rpp_step u_step (
      .state_cur        (state_ff),
      .region_count     (region_count_ff),
      .slots_per_region (slots_per_region_ff),
      .item             (item_ff),
      .state_next       (state_in),
      .result           (result_in)
   );

   // Pointer state moves only when an item passes into the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.enq_region <= '0;
         state_ff.enq_slot   <= '0;
         state_ff.cycle      <= 1'b1;
         state_ff.deq_region <= '0;
         state_ff.deq_slot   <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.stamped      = result_ff.stamped;
   assign rsp_bus.stamp_region = result_ff.stamp_region;
   assign rsp_bus.stamp_slot   = result_ff.stamp_slot;
   assign rsp_bus.stamp_cycle  = result_ff.stamp_cycle;
   assign rsp_bus.link_stamped = result_ff.link_stamped;
   assign rsp_bus.enq_region   = result_ff.enq_region;
   assign rsp_bus.enq_slot     = result_ff.enq_slot;
   assign rsp_bus.cycle_state  = result_ff.cycle_state;
   assign rsp_bus.ring_full    = result_ff.ring_full;

endmodule

// ===== rtl/core/trb_rpp_step.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// trb_rpp_step: pointer update for one item
// Combinational: from the current pointer state, the configuration and one
// item, forms the next pointer state and the result of that item.
// -----------------------------------------------------------------------------
module trb_rpp_step (
   input  trb_rpp_pkg::ptr_state_type                state_cur,
   input  logic [trb_rpp_pkg::RCOUNT_W-1:0]          region_count,
   input  logic [trb_rpp_pkg::SLOT_W-1:0]            slots_per_region,
   input  trb_rpp_pkg::item_type                     item,
   output trb_rpp_pkg::ptr_state_type                state_next,
   output trb_rpp_pkg::result_type                   result
);

   logic [trb_rpp_pkg::RCOUNT_W-1:0] n_regions;
   logic [trb_rpp_pkg::SLOT_W-1:0]   n_slots;
   logic                             last_slot;
   logic                             last_region;
   logic [trb_rpp_pkg::SLOT_W:0]     slot_inc;
   logic [trb_rpp_pkg::RCOUNT_W-1:0] region_inc;
   logic                             wrap_slot;
   logic                             wrap_region;
   logic [trb_rpp_pkg::RCOUNT_W-1:0] look_region;
   logic [trb_rpp_pkg::SLOT_W:0]     look_slot;

   // Out-of-range counts are clamped into their legal ranges.
   always_comb begin
      n_regions = region_count;
      if (n_regions == '0) n_regions = 5'd1;
      if (n_regions > trb_rpp_pkg::MAX_REGIONS) n_regions = trb_rpp_pkg::MAX_REGIONS;
      n_slots = slots_per_region;
      if (n_slots == '0) n_slots = 8'd1;
      if (n_slots > trb_rpp_pkg::MAX_SLOTS) n_slots = trb_rpp_pkg::MAX_SLOTS;
   end

   assign last_slot   = (state_cur.enq_slot == n_slots - 8'd1);
   assign last_region = ({1'b0, state_cur.enq_region} == n_regions - 5'd1);
   assign slot_inc    = {1'b0, state_cur.enq_slot} + 9'd1;
   assign region_inc  = {1'b0, state_cur.enq_region} + 5'd1;
   assign wrap_slot   = (slot_inc >= {1'b0, n_slots});
   assign wrap_region = (region_inc >= n_regions);

   always_comb begin
      state_next = state_cur;
      result     = '0;
      if (item.kind == trb_rpp_pkg::KIND_ADVANCE) begin
         result.stamped      = 1'b1;
         result.stamp_region = state_cur.enq_region;
         result.stamp_slot   = state_cur.enq_slot;
         result.stamp_cycle  = state_cur.cycle;
         result.link_stamped = last_slot;
         // Passing the link of the last region toggles the cycle state.
         if (last_slot && last_region) state_next.cycle = ~state_cur.cycle;
         if (wrap_slot) begin
            state_next.enq_slot   = '0;
            state_next.enq_region = wrap_region ? '0 : region_inc[3:0];
         end else begin
            state_next.enq_slot = slot_inc[7:0];
         end
      end else begin
         state_next.deq_region = item.deq_region;
         state_next.deq_slot   = item.deq_slot;
      end
      result.enq_region  = state_next.enq_region;
      result.enq_slot    = state_next.enq_slot;
      result.cycle_state = state_next.cycle;
      result.ring_full   = ({1'b0, state_next.deq_region} == look_region) &&
                           ({1'b0, state_next.deq_slot} == look_slot);
   end

   // Position of the slot after the updated enqueue position, kept at full
   // width so that a position beyond the configuration never matches.
   always_comb begin
      if (state_next.enq_slot == n_slots - 8'd1) begin
         look_slot = '0;
         if ({1'b0, state_next.enq_region} == n_regions - 5'd1) begin
            look_region = '0;
         end else begin
            look_region = {1'b0, state_next.enq_region} + 5'd1;
         end
      end else begin
         look_slot   = {1'b0, state_next.enq_slot} + 9'd1;
         look_region = {1'b0, state_next.enq_region};
      end
   end

endmodule

// ===== tb/tb_trb_ring_producer_pointer.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_trb_ring_producer_pointer: self-checking bench for the ring producer pointer
// A short scripted sequence covers reset values, shrunken and out-of-range
// region and slot counts, the full flag and cycle-bit toggling. It is followed
// by randomised phases under several ring shapes. Every request beat is run
// through an in-bench pointer model, and each response beat is compared field
// by field with the oldest prediction. Both channels idle at random, with a
// gap-free phase and a long response hold-off.
// -----------------------------------------------------------------------------
module tb_trb_ring_producer_pointer;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SCRIPT_LEN  = 19;

   typedef struct packed {
      logic                    set_cfg;
      logic [7:0]              rc_data;
      logic [7:0]              spr_data;
      trb_rpp_pkg::item_type   beat;
      logic                    typed;
      trb_rpp_pkg::result_type want;
   } script_row_type;

   // Fields: set_cfg, region_count data, slots_per_region data, beat
   // {kind, deq_region, deq_slot}, typed, and the result typed in by hand
   // {stamped, stamp_region, stamp_slot, stamp_cycle, link_stamped,
   //  enq_region, enq_slot, cycle_state, ring_full}.
   localparam script_row_type SCRIPT [0:SCRIPT_LEN-1] = '{
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b1,
       {1'b1, 4'd0, 8'd0, 1'b1, 1'b0, 4'd0, 8'd1, 1'b1, 1'b0}},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_DEQUEUE, 4'd0,  8'd2},   1'b1,
       {1'b0, 4'd0, 8'd0, 1'b0, 1'b0, 4'd0, 8'd1, 1'b1, 1'b1}},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b1,
       {1'b1, 4'd0, 8'd1, 1'b1, 1'b0, 4'd0, 8'd2, 1'b1, 1'b0}},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_DEQUEUE, 4'd15, 8'd255}, 1'b1,
       {1'b0, 4'd0, 8'd0, 1'b0, 1'b0, 4'd0, 8'd2, 1'b1, 1'b0}},
      {1'b1, 8'h01, 8'h01, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd9,  8'd170}, 1'b1,
       {1'b1, 4'd0, 8'd0, 1'b1, 1'b1, 4'd0, 8'd0, 1'b0, 1'b0}},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_DEQUEUE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd6,  8'd85},  1'b0, 29'd0},
      {1'b1, 8'hFF, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b1, 8'h10, 8'hFF, {trb_rpp_pkg::KIND_DEQUEUE, 4'd3,  8'd0},   1'b0, 29'd0},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b1, 8'h11, 8'h02, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_DEQUEUE, 4'd15, 8'd254}, 1'b0, 29'd0},
      {1'b1, 8'h00, 8'h01, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b0, 8'h00, 8'h00, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0},
      {1'b1, 8'h01, 8'hFF, {trb_rpp_pkg::KIND_ADVANCE, 4'd0,  8'd0},   1'b0, 29'd0}
   };

   logic                               clock;
   logic                               reset;
   logic                               csr_write_enable;
   logic                               csr_index;
   logic [trb_rpp_pkg::CSR_DATA_W-1:0] csr_write_data;

   trb_rpp_req_if req_bus ();
   trb_rpp_rsp_if rsp_bus ();

   trb_ring_producer_pointer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Pointer model state and its copy of the registers.
   trb_rpp_pkg::ptr_state_type       ring_ptr;
   logic [trb_rpp_pkg::RCOUNT_W-1:0] model_regions;
   logic [trb_rpp_pkg::SLOT_W-1:0]   model_slots;

   trb_rpp_pkg::result_type pointer_reports_q [$];
   int          mismatches = 0;
   int unsigned cycle_count = 0;
   bit          no_gaps = 1'b0;
   bit          stall_req = 1'b0;
   int          hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int regions_in_use();
      if (model_regions < 1) return 1;
      if (model_regions > trb_rpp_pkg::MAX_REGIONS) return int'(trb_rpp_pkg::MAX_REGIONS);
      return int'(model_regions);
   endfunction

   function automatic int slots_in_use();
      if (model_slots < 1) return 1;
      return int'(model_slots);
   endfunction

   // Position of the slot after the enqueue pointer, at full integer width.
   function automatic void slot_after_enqueue(output int nr, output int ns);
      if (ring_ptr.enq_slot == slots_in_use() - 1) begin
         nr = (ring_ptr.enq_region == regions_in_use() - 1) ? 0 : ring_ptr.enq_region + 1;
         ns = 0;
      end else begin
         nr = int'(ring_ptr.enq_region);
         ns = ring_ptr.enq_slot + 1;
      end
   endfunction

   function automatic trb_rpp_pkg::result_type ring_pointer_next(trb_rpp_pkg::item_type beat);
      trb_rpp_pkg::result_type rep;
      int         nslots;
      int         nregions;
      int         slot_i;
      int         region_i;
      int         nr;
      int         ns;
      rep = '0;
      nslots = slots_in_use();
      nregions = regions_in_use();
      if (beat.kind == trb_rpp_pkg::KIND_ADVANCE) begin
         rep.stamped = 1'b1;
         rep.stamp_region = ring_ptr.enq_region;
         rep.stamp_slot = ring_ptr.enq_slot;
         rep.stamp_cycle = ring_ptr.cycle;
         if (ring_ptr.enq_slot == nslots - 1) begin
            rep.link_stamped = 1'b1;
            if (ring_ptr.enq_region == nregions - 1) ring_ptr.cycle = ~ring_ptr.cycle;
         end
         // A pointer left beyond a shrunken ring still wraps on the next step.
         slot_i = ring_ptr.enq_slot + 1;
         region_i = int'(ring_ptr.enq_region);
         if (slot_i >= nslots) begin
            slot_i = 0;
            region_i++;
            if (region_i >= nregions) region_i = 0;
         end
         ring_ptr.enq_slot = slot_i[trb_rpp_pkg::SLOT_W-1:0];
         ring_ptr.enq_region = region_i[trb_rpp_pkg::REGION_W-1:0];
      end else begin
         ring_ptr.deq_region = beat.deq_region;
         ring_ptr.deq_slot = beat.deq_slot;
      end
      rep.enq_region = ring_ptr.enq_region;
      rep.enq_slot = ring_ptr.enq_slot;
      rep.cycle_state = ring_ptr.cycle;
      slot_after_enqueue(nr, ns);
      rep.ring_full = (nr == ring_ptr.deq_region) && (ns == ring_ptr.deq_slot);
      return rep;
   endfunction

   // Dequeue updates mostly land just after the producer to provoke the full
   // flag, or elsewhere inside the ring; a few are arbitrary.
   function automatic trb_rpp_pkg::item_type random_beat(int advance_pct);
      trb_rpp_pkg::item_type beat;
      int       nr;
      int       ns;
      int       pick;
      beat.deq_region = 4'($urandom_range(15));
      beat.deq_slot = 8'($urandom_range(255));
      if ($urandom_range(99) < advance_pct) begin
         beat.kind = trb_rpp_pkg::KIND_ADVANCE;
      end else begin
         beat.kind = trb_rpp_pkg::KIND_DEQUEUE;
         pick = $urandom_range(9);
         if (pick < 5) begin
            slot_after_enqueue(nr, ns);
            beat.deq_region = nr[trb_rpp_pkg::REGION_W-1:0];
            beat.deq_slot = ns[trb_rpp_pkg::SLOT_W-1:0];
         end else if (pick < 8) begin
            beat.deq_region = 4'($urandom_range(regions_in_use() - 1));
            beat.deq_slot = 8'($urandom_range(slots_in_use() - 1));
         end
      end
      return beat;
   endfunction

   task automatic send_beat(trb_rpp_pkg::item_type beat, logic use_typed,
                            trb_rpp_pkg::result_type typed_want);
      trb_rpp_pkg::result_type predicted;
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < 21) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= beat.kind;
      req_bus.deq_region <= beat.deq_region;
      req_bus.deq_slot <= beat.deq_slot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = ring_pointer_next(beat);
      pointer_reports_q.push_back(use_typed ? typed_want : predicted);
   endtask

   // Lowers valid and holds off until every predicted beat has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pointer_reports_q.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic index, logic [trb_rpp_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      if (index == trb_rpp_pkg::CSR_REGION_COUNT) begin
         model_regions = data[trb_rpp_pkg::RCOUNT_W-1:0];
      end else begin
         model_slots = data[trb_rpp_pkg::SLOT_W-1:0];
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_ring_shape(logic [7:0] rc_data, logic [7:0] spr_data);
      wait_for_drain();
      csr_write(trb_rpp_pkg::CSR_REGION_COUNT, rc_data);
      csr_write(trb_rpp_pkg::CSR_SLOTS_PER_REGION, spr_data);
   endtask

   // Response side: random back-pressure, plus a long hold-off on request.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_req) begin
            stall_req = 1'b0;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (no_gaps) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 21);
         end
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_monitor
      trb_rpp_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pointer_reports_q.size() == 0) begin
            $error("response beat with no prediction waiting");
            mismatches++;
         end else begin
            want = pointer_reports_q.pop_front();
            check_field("stamped", 8'(want.stamped), 8'(rsp_bus.stamped));
            check_field("stamp_region", 8'(want.stamp_region), 8'(rsp_bus.stamp_region));
            check_field("stamp_slot", want.stamp_slot, rsp_bus.stamp_slot);
            check_field("stamp_cycle", 8'(want.stamp_cycle), 8'(rsp_bus.stamp_cycle));
            check_field("link_stamped", 8'(want.link_stamped), 8'(rsp_bus.link_stamped));
            check_field("enq_region", 8'(want.enq_region), 8'(rsp_bus.enq_region));
            check_field("enq_slot", want.enq_slot, rsp_bus.enq_slot);
            check_field("cycle_state", 8'(want.cycle_state), 8'(rsp_bus.cycle_state));
            check_field("ring_full", 8'(want.ring_full), 8'(rsp_bus.ring_full));
         end
      end
   end

   initial begin : stimulus
      script_row_type row;
      logic [7:0]     rc;
      logic [7:0]     spr;
      int             beats;
      int             advance_pct;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = trb_rpp_pkg::CSR_REGION_COUNT;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = trb_rpp_pkg::KIND_ADVANCE;
      req_bus.deq_region = '0;
      req_bus.deq_slot = '0;
      ring_ptr = '{enq_region: '0, enq_slot: '0, cycle: 1'b1, deq_region: '0, deq_slot: '0};
      model_regions = trb_rpp_pkg::REGION_COUNT_RESET;
      model_slots = trb_rpp_pkg::SLOTS_PER_REGION_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < SCRIPT_LEN; k++) begin
         row = SCRIPT[k];
         if (row.set_cfg) set_ring_shape(row.rc_data, row.spr_data);
         send_beat(row.beat, row.typed, row.want);
      end

      for (int phase = 0; phase < 8; phase++) begin
         advance_pct = 75;
         beats = 60;
         case (phase)
            0: begin
               // One full-size region: long enough to walk every slot and wrap.
               rc = 8'd1;
               spr = 8'd255;
               beats = 300;
               advance_pct = 90;
            end
            1: begin
               rc = 8'd16;
               spr = 8'd1;
               beats = 80;
               advance_pct = 80;
            end
            2: begin
               rc = 8'd0;
               spr = 8'd0;
               beats = 40;
               advance_pct = 70;
            end
            3: begin
               rc = 8'($urandom_range(2, 16)) | 8'($urandom_range(7) << 5);
               spr = 8'($urandom_range(1, 8));
               beats = 100;
            end
            4: begin
               rc = 8'd4;
               spr = 8'd5;
               beats = 100;
            end
            default: begin
               rc = 8'($urandom_range(255));
               spr = 8'($urandom_range(255));
            end
         endcase
         set_ring_shape(rc, spr);
         no_gaps = (phase == 3);
         if (phase == 4) stall_req = 1'b1;
         repeat (beats) send_beat(random_beat(advance_pct), 1'b0, '0);
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
